/* rtl/delta_list_timer_queue_assert.svh */
// Assertion macros used by the timer queue sequencer RTL.
`ifndef DELTA_LIST_TIMER_QUEUE_ASSERT_SVH
`define DELTA_LIST_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DLTQ_CHECK(name, ck, rs, cond, prop) \
  name: assert property (@(posedge ck) disable iff (rs) (cond) |-> (prop)) \
    else $error("dltq check failed");

// Next-cycle implication, checked outside reset.
`define DLTQ_CHECK_NEXT(name, ck, rs, cond, prop) \
  name: assert property (@(posedge ck) disable iff (rs) (cond) |=> (prop)) \
    else $error("dltq check failed");

`endif

/* rtl/dltq_pkg.sv */
// Types and constants shared by the timer queue modules.
`default_nettype none

package dltq_pkg;

  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  localparam logic [2:0] EV_STARTED   = 3'd0;
  localparam logic [2:0] EV_QUEUED    = 3'd1;
  localparam logic [2:0] EV_CANCELLED = 3'd2;
  localparam logic [2:0] EV_UNQUEUED  = 3'd3;
  localparam logic [2:0] EV_FIRED     = 3'd4;

  localparam int          MAX_RESULTS = 16;
  localparam logic [30:0] DELTA_MAX   = 31'h7FFF_FFFF;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ST_CHK,
    S_WK_RD,
    S_WK_CMP,
    S_WK_SUB,
    S_INS_W1,
    S_INS_W2,
    S_CN_CHK,
    S_CN_LD,
    S_CN_ADD,
    S_CN_UNLINK,
    S_TK_RD,
    S_TK_CHK,
    S_TK_END,
    S_RES
  } state_t;

  typedef struct packed {
    logic       valid;
    logic [2:0] ev;
    logic [3:0] id;
    logic       last;
  } emit_t;

endpackage

`default_nettype wire

/* rtl/dltq_ram.sv */
// Single-write, single-read RAM with registered read data.
`default_nettype none

module dltq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/dltq_alu.sv */
// Shared 31-bit add/subtract unit with carry or borrow in the top bit.
`default_nettype none

module dltq_alu (
  input  wire dltq_pkg::alu_op_t op,
  input  wire logic [30:0]       a,
  input  wire logic [30:0]       b,
  output      logic [31:0]       res
);
  import dltq_pkg::*;

  always_comb begin
    unique case (op)
      ALU_ADD: res = {1'b0, a} + {1'b0, b};
      ALU_SUB: res = {1'b0, a} - {1'b0, b};
    endcase
  end

endmodule

`default_nettype wire

/* rtl/dltq_seq.sv */
// Sequencer that walks and edits the linked timer list through one shared adder.
`default_nettype none

`include "delta_list_timer_queue_assert.svh"

module dltq_seq #(
  parameter int TIMER_COUNT = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_accept,
  input  wire logic [1:0]     kind,
  input  wire logic [3:0]     timer_id,
  input  wire logic [30:0]    delay,
  input  wire logic           out_free,
  output      logic           ready,
  output      dltq_pkg::emit_t emit,
  output      logic [31:0]    tick_count
);
  import dltq_pkg::*;

  localparam int LW = $clog2(TIMER_COUNT + 1);
  localparam int IW = $clog2(TIMER_COUNT);
  localparam int FW = $clog2(MAX_RESULTS + 1);
  localparam logic [LW-1:0] NoneLink = LW'(TIMER_COUNT);

  state_t                 state, state_next;
  logic [LW-1:0]          head, head_next;
  logic [LW-1:0]          tail, tail_next;
  logic [LW-1:0]          cur, cur_next;
  logic [LW-1:0]          pl, pl_next;
  logic [30:0]            dval, dval_next;
  logic [3:0]             id_r, id_next;
  logic [TIMER_COUNT-1:0] queued, queued_next;
  logic [FW-1:0]          fired, fired_next;
  logic                   pend, pend_next;
  logic [LW-1:0]          pend_id, pend_id_next;
  logic [2:0]             res, res_next;
  logic [31:0]            tick_counter, tick_counter_next;

  logic          nx_we, pv_we, dl_we;
  logic [IW-1:0] nx_waddr, pv_waddr, dl_waddr;
  logic [IW-1:0] nx_raddr, pv_raddr, dl_raddr;
  logic [LW-1:0] nx_wdata, pv_wdata, nx_rdata, pv_rdata;
  logic [30:0]   dl_wdata, dl_rdata;

  alu_op_t     alu_op;
  logic [30:0] alu_a, alu_b;
  logic [31:0] alu_res;

  logic          id_ok;
  logic [LW-1:0] id_link;
  logic [IW-1:0] id_idx;
  logic [30:0]   sat_sum;
  logic          kind_ok;

  assign id_ok   = ({28'd0, id_r} < 32'(TIMER_COUNT));
  assign id_link = LW'(id_r);
  assign id_idx  = id_link[IW-1:0];
  assign sat_sum = alu_res[31] ? DELTA_MAX : alu_res[30:0];
  assign tick_count = tick_counter;
  assign kind_ok = (kind == KIND_START) || (kind == KIND_CANCEL) || (kind == KIND_TICK);

  dltq_ram #(.WIDTH(LW), .DEPTH(TIMER_COUNT)) u_next (
    .clk(clk), .we(nx_we), .waddr(nx_waddr), .wdata(nx_wdata),
    .raddr(nx_raddr), .rdata(nx_rdata)
  );

  dltq_ram #(.WIDTH(LW), .DEPTH(TIMER_COUNT)) u_prev (
    .clk(clk), .we(pv_we), .waddr(pv_waddr), .wdata(pv_wdata),
    .raddr(pv_raddr), .rdata(pv_rdata)
  );

  dltq_ram #(.WIDTH(31), .DEPTH(TIMER_COUNT)) u_delta (
    .clk(clk), .we(dl_we), .waddr(dl_waddr), .wdata(dl_wdata),
    .raddr(dl_raddr), .rdata(dl_rdata)
  );

  dltq_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .res(alu_res));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= NoneLink;
      tail         <= NoneLink;
      queued       <= '0;
      fired        <= '0;
      pend         <= 1'b0;
      tick_counter <= '0;
    end else begin
      state        <= state_next;
      head         <= head_next;
      tail         <= tail_next;
      queued       <= queued_next;
      fired        <= fired_next;
      pend         <= pend_next;
      tick_counter <= tick_counter_next;
    end
  end

  always_ff @(posedge clk) begin
    cur     <= cur_next;
    pl      <= pl_next;
    dval    <= dval_next;
    id_r    <= id_next;
    pend_id <= pend_id_next;
    res     <= res_next;
  end

  always_comb begin
    state_next        = state;
    head_next         = head;
    tail_next         = tail;
    cur_next          = cur;
    pl_next           = pl;
    dval_next         = dval;
    id_next           = id_r;
    queued_next       = queued;
    fired_next        = fired;
    pend_next         = pend;
    pend_id_next      = pend_id;
    res_next          = res;
    tick_counter_next = tick_counter;

    nx_we    = 1'b0;
    nx_waddr = cur[IW-1:0];
    nx_wdata = cur;
    nx_raddr = cur[IW-1:0];
    pv_we    = 1'b0;
    pv_waddr = cur[IW-1:0];
    pv_wdata = pl;
    pv_raddr = cur[IW-1:0];
    dl_we    = 1'b0;
    dl_waddr = cur[IW-1:0];
    dl_wdata = alu_res[30:0];
    dl_raddr = cur[IW-1:0];

    alu_op = ALU_SUB;
    alu_a  = dl_rdata;
    alu_b  = dval;
    emit   = '0;
    ready  = 1'b0;

    unique case (state)
      S_IDLE: begin
        ready = 1'b1;
        if (in_accept) begin
          id_next   = timer_id;
          dval_next = delay;
          unique case (kind)
            KIND_START:  state_next = S_ST_CHK;
            KIND_CANCEL: state_next = S_CN_CHK;
            KIND_TICK: begin
              tick_counter_next = tick_counter + 32'd1;
              fired_next        = '0;
              pend_next         = 1'b0;
              state_next        = S_TK_RD;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      S_ST_CHK: begin
        if (!id_ok || queued[id_idx]) begin
          res_next   = EV_QUEUED;
          state_next = S_RES;
        end else begin
          cur_next   = head;
          state_next = S_WK_RD;
        end
      end

      S_WK_RD: begin
        if (cur == NoneLink) begin
          state_next = S_INS_W1;
        end else begin
          state_next = S_WK_CMP;
        end
      end

      S_WK_CMP: begin
        alu_a = dval;
        alu_b = dl_rdata;
        if (alu_res[31]) begin
          // This entry fires later than the new timer: insert in front of it.
          state_next = S_WK_SUB;
        end else begin
          dval_next  = alu_res[30:0];
          cur_next   = nx_rdata;
          state_next = S_WK_RD;
        end
      end

      S_WK_SUB: begin
        alu_a      = dl_rdata;
        alu_b      = dval;
        dl_we      = 1'b1;
        state_next = S_INS_W1;
      end

      S_INS_W1: begin
        pl_next  = (cur == NoneLink) ? tail : pv_rdata;
        dl_we    = 1'b1;
        dl_waddr = id_idx;
        dl_wdata = dval;
        pv_we    = 1'b1;
        pv_waddr = id_idx;
        pv_wdata = (cur == NoneLink) ? tail : pv_rdata;
        nx_we    = 1'b1;
        nx_waddr = id_idx;
        nx_wdata = cur;
        state_next = S_INS_W2;
      end

      S_INS_W2: begin
        if (pl != NoneLink) begin
          nx_we    = 1'b1;
          nx_waddr = pl[IW-1:0];
          nx_wdata = id_link;
        end else begin
          head_next = id_link;
        end
        if (cur != NoneLink) begin
          pv_we    = 1'b1;
          pv_wdata = id_link;
        end else begin
          tail_next = id_link;
        end
        queued_next[id_idx] = 1'b1;
        res_next   = EV_STARTED;
        state_next = S_RES;
      end

      S_CN_CHK: begin
        nx_raddr = id_idx;
        pv_raddr = id_idx;
        dl_raddr = id_idx;
        if (!id_ok || !queued[id_idx]) begin
          res_next   = EV_UNQUEUED;
          state_next = S_RES;
        end else begin
          state_next = S_CN_LD;
        end
      end

      S_CN_LD: begin
        cur_next  = nx_rdata;
        pl_next   = pv_rdata;
        dval_next = dl_rdata;
        dl_raddr  = nx_rdata[IW-1:0];
        if (nx_rdata != NoneLink) begin
          state_next = S_CN_ADD;
        end else begin
          state_next = S_CN_UNLINK;
        end
      end

      S_CN_ADD: begin
        alu_op     = ALU_ADD;
        dl_we      = 1'b1;
        dl_wdata   = sat_sum;
        state_next = S_CN_UNLINK;
      end

      S_CN_UNLINK: begin
        if (pl != NoneLink) begin
          nx_we    = 1'b1;
          nx_waddr = pl[IW-1:0];
          nx_wdata = cur;
        end else begin
          head_next = cur;
        end
        if (cur != NoneLink) begin
          pv_we = 1'b1;
        end else begin
          tail_next = pl;
        end
        queued_next[id_idx] = 1'b0;
        res_next   = EV_CANCELLED;
        state_next = S_RES;
      end

      S_TK_RD: begin
        nx_raddr = head[IW-1:0];
        dl_raddr = head[IW-1:0];
        if (head == NoneLink) begin
          state_next = S_TK_END;
        end else begin
          state_next = S_TK_CHK;
        end
      end

      S_TK_CHK: begin
        nx_raddr = head[IW-1:0];
        dl_raddr = head[IW-1:0];
        if (dl_rdata != 31'd0) begin
          alu_b      = 31'd1;
          dl_we      = 1'b1;
          dl_waddr   = head[IW-1:0];
          state_next = S_TK_END;
        end else if (fired == FW'(MAX_RESULTS)) begin
          state_next = S_TK_END;
        end else if (!pend || out_free) begin
          // Hand out the previous firing, then hold this one back until we
          // know whether it is the last of the tick.
          if (pend) begin
            emit = '{valid: 1'b1, ev: EV_FIRED, id: 4'(pend_id), last: 1'b0};
          end
          pend_next    = 1'b1;
          pend_id_next = head;
          fired_next   = fired + FW'(1);
          head_next    = nx_rdata;
          queued_next[head[IW-1:0]] = 1'b0;
          if (nx_rdata != NoneLink) begin
            pv_we    = 1'b1;
            pv_waddr = nx_rdata[IW-1:0];
            pv_wdata = NoneLink;
          end else begin
            tail_next = NoneLink;
          end
          state_next = S_TK_RD;
        end
      end

      S_TK_END: begin
        if (!pend) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          emit = '{valid: 1'b1, ev: EV_FIRED, id: 4'(pend_id), last: 1'b1};
          pend_next  = 1'b0;
          state_next = S_IDLE;
        end
      end

      S_RES: begin
        if (out_free) begin
          emit = '{valid: 1'b1, ev: res, id: id_r, last: 1'b1};
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  `DLTQ_CHECK(a_head_empty_tail_empty, clk, rst, head == NoneLink, tail == NoneLink)
  `DLTQ_CHECK(a_tail_empty_head_empty, clk, rst, tail == NoneLink, head == NoneLink)
  `DLTQ_CHECK(a_fired_bound, clk, rst, 1'b1, fired <= FW'(MAX_RESULTS))
  `DLTQ_CHECK(a_emit_when_free, clk, rst, emit.valid, out_free)
  `DLTQ_CHECK_NEXT(a_accept_busy, clk, rst, in_accept && kind_ok, state != S_IDLE)

endmodule

`default_nettype wire

/* rtl/delta_list_timer_queue.sv */
// A start walks past the earlier entries, trims the entry it lands ahead of, then links in.
// A cancel adds its delta to any successor, then unlinks; a refused start or cancel skips the list.
// A tick pops each due timer in turn; one word is in work at a time.
// An input word is taken again as soon as the sequencer is idle, even while a result waits.
// Reset (rst, synchronous, active high) empties the queue and clears the tick counter.
// The link and delta RAMs are not cleared; only entries of queued timers are ever read.
`default_nettype none

module delta_list_timer_queue #(
  parameter int TIMER_COUNT = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream.
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  input  wire logic [39:0] s_tdata,  // timer_id [3:0], delay [34:4], zero pad [39:35]
  input  wire logic [1:0]  s_tuser,  // kind [1:0]
  // Result stream.
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  output      logic [39:0] m_tdata,  // timer_id_res [3:0], tick_count [35:4], zero [39:36]
  output      logic [2:0]  m_tuser,  // event_res [2:0]
  output      logic        m_tlast   // last
);
  import dltq_pkg::*;

  logic        in_accept;
  logic        out_free;
  emit_t       emit;
  logic [31:0] tick_count;
  logic [3:0]  out_id;
  logic [31:0] out_ticks;

  // A word is taken whenever the sequencer is idle.
  assign in_accept = s_tvalid && s_tready;

  // The output register can take a new word when it is empty or being drained
  // in this same cycle.
  assign out_free = !m_tvalid || m_tready;

  dltq_seq #(.TIMER_COUNT(TIMER_COUNT)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .in_accept  (in_accept),
    .kind       (s_tuser),
    .timer_id   (s_tdata[3:0]),
    .delay      (s_tdata[34:4]),
    .out_free   (out_free),
    .ready      (s_tready),
    .emit       (emit),
    .tick_count (tick_count)
  );

  // Output register: it separates the sequencer from the downstream ready, so
  // the sequencer only stalls when a second result is due while one still waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit.valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  // Payload is captured with the tick counter as it stands after the current word.
  always_ff @(posedge clk) begin
    if (emit.valid) begin
      m_tuser   <= emit.ev;
      out_id    <= emit.id;
      out_ticks <= tick_count;
      m_tlast   <= emit.last;
    end
  end

  assign m_tdata = {4'd0, out_ticks, out_id};

endmodule

`default_nettype wire

/* tb/sv/tb_delta_list_timer_queue.sv */
// Stream testbench for the delta-list timer queue with its own predictor and result checks.
module tb_delta_list_timer_queue;
  import dltq_pkg::*;

  localparam int TIMERS = 16;
  localparam logic [4:0] NO_LINK = 5'd16;
  localparam int RANDOM_WORDS = 320;
  // Once this few words are left to send, neither side idles any more.
  localparam int QUIET_TAIL = 40;
  // The receiver's long hold-off starts after this many input words and lasts this long.
  localparam int HOLD_AFTER = 60;
  localparam int HOLD_CYCLES = 400;

  // One input word as the sender sees it.
  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  id;
    logic [30:0] delay;
  } timer_cmd_t;

  // One result word as the receiver should see it.
  typedef struct packed {
    logic [2:0]  ev;
    logic [3:0]  id;
    logic [31:0] ticks;
    logic        last;
  } timer_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;  // timer_id [3:0], delay [34:4], zero pad [39:35]
  logic [1:0]  s_tuser = '0;  // kind [1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;       // timer_id_res [3:0], tick_count [35:4], zero [39:36]
  logic [2:0]  m_tuser;       // event_res [2:0]
  logic        m_tlast;       // last

  delta_list_timer_queue #(.TIMER_COUNT(TIMERS)) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always #1 clk = ~clk;

  // Words waiting to be offered, and results the block still owes.
  timer_cmd_t    pending_cmds[$];
  timer_result_t owed_results[$];
  bit            failed = 1'b0;

  // Predictor state: a doubly linked list of timers, each holding the ticks it
  // waits after its predecessor fires. NO_LINK marks the end of the list.
  logic [4:0]  nxt[TIMERS];
  logic [4:0]  prv[TIMERS];
  logic [30:0] dlt[TIMERS];
  bit          on_list[TIMERS];
  logic [4:0]  head_ix = NO_LINK;
  logic [4:0]  tail_ix = NO_LINK;
  logic [31:0] ticks = '0;

  task automatic drop_from_list(input logic [4:0] t);
    logic [4:0] p;
    logic [4:0] n;
    p = prv[t];
    n = nxt[t];
    if (p != NO_LINK) nxt[p] = n;
    else head_ix = n;
    if (n != NO_LINK) prv[n] = p;
    else tail_ix = p;
    nxt[t] = NO_LINK;
    prv[t] = NO_LINK;
    on_list[t] = 1'b0;
  endtask

  // Applies one accepted word to the predicted list and queues the results it causes.
  task automatic advance_timer_list(input timer_cmd_t w);
    logic [4:0]    cur;
    logic [4:0]    p;
    logic [4:0]    n;
    logic [4:0]    t;
    logic [30:0]   d;
    logic [31:0]   sum;
    logic [3:0]    popped[MAX_RESULTS];
    int            steps;
    int            fired;
    bit            walking;
    timer_result_t r;
    t = {1'b0, w.id};
    r.id = w.id;
    r.last = 1'b1;
    case (w.kind)
      KIND_START: begin
        if (on_list[t]) begin
          r.ev = EV_QUEUED;
        end else begin
          // Walk past every entry that fires no later; ties go behind.
          cur = head_ix;
          d = w.delay;
          steps = 0;
          walking = 1'b1;
          while (walking && cur != NO_LINK && steps < TIMERS) begin
            if (dlt[cur] > d) begin
              dlt[cur] = dlt[cur] - d;
              walking = 1'b0;
            end else begin
              d = d - dlt[cur];
              cur = nxt[cur];
              steps++;
            end
          end
          if (steps >= TIMERS) cur = NO_LINK;
          dlt[t] = d;
          p = (cur != NO_LINK) ? prv[cur] : tail_ix;
          prv[t] = p;
          nxt[t] = cur;
          if (p != NO_LINK) nxt[p] = t;
          else head_ix = t;
          if (cur != NO_LINK) prv[cur] = t;
          else tail_ix = t;
          on_list[t] = 1'b1;
          r.ev = EV_STARTED;
        end
        r.ticks = ticks;
        owed_results.push_back(r);
      end
      KIND_CANCEL: begin
        if (!on_list[t]) begin
          r.ev = EV_UNQUEUED;
        end else begin
          // The successor inherits the removed delta, saturating at the top.
          n = nxt[t];
          if (n != NO_LINK) begin
            sum = {1'b0, dlt[n]} + {1'b0, dlt[t]};
            dlt[n] = (sum > {1'b0, DELTA_MAX}) ? DELTA_MAX : sum[30:0];
          end
          drop_from_list(t);
          r.ev = EV_CANCELLED;
        end
        r.ticks = ticks;
        owed_results.push_back(r);
      end
      KIND_TICK: begin
        ticks = ticks + 32'd1;
        fired = 0;
        walking = 1'b1;
        while (walking && head_ix != NO_LINK) begin
          cur = head_ix;
          if (dlt[cur] > 0) begin
            dlt[cur] = dlt[cur] - 31'd1;
            walking = 1'b0;
          end else if (fired >= MAX_RESULTS) begin
            walking = 1'b0;
          end else begin
            drop_from_list(cur);
            popped[fired] = cur[3:0];
            fired++;
          end
        end
        for (int i = 0; i < fired; i++) begin
          r.ev = EV_FIRED;
          r.id = popped[i];
          r.ticks = ticks;
          r.last = (i == fired - 1);
          owed_results.push_back(r);
        end
      end
      default: ;  // The fourth kind is ignored by the block.
    endcase
  endtask

  // Stimulus generation keeps a rough view of which timers are queued, by
  // absolute firing tick, so that most cancels hit a live timer and most
  // starts pick a free one.
  longint gen_ticks = 0;
  longint fire_at[TIMERS];
  bit     maybe_queued[TIMERS];

  task automatic add_word(input logic [1:0] kind, input logic [3:0] id,
                          input logic [30:0] delay);
    timer_cmd_t w;
    w.kind = kind;
    w.id = id;
    w.delay = delay;
    pending_cmds.push_back(w);
    if (kind == KIND_START && !maybe_queued[id]) begin
      maybe_queued[id] = 1'b1;
      fire_at[id] = gen_ticks + longint'(delay) + 1;
    end else if (kind == KIND_CANCEL) begin
      maybe_queued[id] = 1'b0;
    end else if (kind == KIND_TICK) begin
      gen_ticks++;
      for (int i = 0; i < TIMERS; i++)
        if (maybe_queued[i] && fire_at[i] <= gen_ticks) maybe_queued[i] = 1'b0;
    end
  endtask

  // Picks a slot whose queued state matches the wish, or any slot if none does.
  function automatic logic [3:0] pick_slot(input bit want_queued);
    int base;
    base = $urandom_range(0, TIMERS - 1);
    for (int i = 0; i < TIMERS; i++)
      if (maybe_queued[(base + i) % TIMERS] == want_queued) return 4'((base + i) % TIMERS);
    return 4'(base);
  endfunction

  initial begin
    int          count;
    int          pick;
    int          sel;
    int          burst;
    logic [30:0] d;
    for (int i = 0; i < TIMERS; i++) begin
      maybe_queued[i] = 1'b0;
      fire_at[i] = 0;
      on_list[i] = 1'b0;
      nxt[i] = NO_LINK;
      prv[i] = NO_LINK;
      dlt[i] = '0;
    end

    // Directed part. A tick on an empty queue fires nothing, a cancel of an
    // idle timer is refused, and the unused kind is ignored.
    add_word(KIND_TICK, 4'd0, 31'd0);
    add_word(KIND_CANCEL, 4'd5, 31'd0);
    add_word(2'd3, 4'hF, DELTA_MAX);
    // Largest delay, then a second start of the same timer is refused.
    add_word(KIND_START, 4'd0, DELTA_MAX);
    add_word(KIND_START, 4'd0, 31'd3);
    // Timer 15 lands in front of timer 0; cancelling it hands its whole delta
    // back to timer 0, which ends exactly at the largest delta.
    add_word(KIND_START, 4'd15, 31'h4000_0000);
    add_word(KIND_CANCEL, 4'd15, 31'd0);
    add_word(KIND_CANCEL, 4'd0, 31'd0);
    // Every timer due on the same tick, in scrambled order with equal delays:
    // one tick pops the full set in start order.
    for (int i = 0; i < TIMERS; i++) add_word(KIND_START, 4'((i * 7 + 3) % TIMERS), 31'd0);
    add_word(KIND_TICK, 4'd0, 31'd0);

    // Random part: mostly live starts, cancels and runs of ticks.
    count = 0;
    while (count < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        sel = $urandom_range(0, 99);
        if (sel < 60) d = 31'($urandom_range(0, 12));
        else if (sel < 88) d = 31'($urandom_range(0, 200));
        else if (sel < 95) d = 31'($urandom);
        else d = ($urandom_range(0, 1) != 0) ? DELTA_MAX : 31'd0;
        add_word(KIND_START, ($urandom_range(0, 4) != 0) ? pick_slot(1'b0)
                                                          : 4'($urandom), d);
        count++;
      end else if (pick < 50) begin
        add_word(KIND_CANCEL, ($urandom_range(0, 3) != 0) ? pick_slot(1'b1)
                                                         : 4'($urandom), 31'($urandom));
        count++;
      end else if (pick < 98) begin
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 8) : 1;
        for (int i = 0; i < burst; i++) add_word(KIND_TICK, 4'($urandom), 31'($urandom));
        count += burst;
      end else begin
        add_word(2'd3, 4'($urandom), 31'($urandom));
      end
    end
  end

  // Reset is held from time zero and released at a falling edge.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // Sampled at the rising edge: acceptance on both sides.
  timer_cmd_t    offered = '0;
  bit            in_taken = 1'b0;
  int            words_in = 0;
  timer_result_t seen;
  timer_result_t want;

  always @(posedge clk) begin
    in_taken = !rst && s_tvalid && s_tready;
    if (in_taken) begin
      advance_timer_list(offered);
      words_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      seen.ev = m_tuser;
      seen.id = m_tdata[3:0];
      seen.ticks = m_tdata[35:4];
      seen.last = m_tlast;
      if (owed_results.size() == 0) begin
        $error("result word with nothing owed: event_res %0d timer_id_res %0d tick_count %0d",
               seen.ev, seen.id, seen.ticks);
        failed = 1'b1;
      end else begin
        want = owed_results.pop_front();
        if (seen.ev != want.ev) begin
          $error("event_res: expected %0d, got %0d", want.ev, seen.ev);
          failed = 1'b1;
        end
        if (seen.id != want.id) begin
          $error("timer_id_res: expected %0d, got %0d", want.id, seen.id);
          failed = 1'b1;
        end
        if (seen.ticks != want.ticks) begin
          $error("tick_count: expected %0d, got %0d", want.ticks, seen.ticks);
          failed = 1'b1;
        end
        if (seen.last != want.last) begin
          $error("last: expected %0d, got %0d", want.last, seen.last);
          failed = 1'b1;
        end
      end
    end
  end

  // Sender: holds a word until it is taken, then either pauses for a burst or
  // offers the next one straight away.
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst) begin
      if (s_tvalid && !in_taken) begin
        // Still waiting for the block to take the current word.
      end else if (gap_left > 0) begin
        s_tvalid <= 1'b0;
        gap_left--;
      end else if (pending_cmds.size() > 0) begin
        offered = pending_cmds.pop_front();
        s_tdata <= {5'b0, offered.delay, offered.id};
        s_tuser <= offered.kind;
        s_tvalid <= 1'b1;
        if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 16);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off so that results
  // back up and the block stops taking input words.
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else if (!hold_done && words_in >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (pending_cmds.size() >= QUIET_TAIL && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 16) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // End of run: everything sent, everything owed has arrived, then a quiet
  // stretch so that a stray extra result is still caught.
  initial begin
    @(negedge rst);
    while (pending_cmds.size() > 0 || s_tvalid) @(posedge clk);
    while (owed_results.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (owed_results.size() != 0) begin
      $error("%0d result words never arrived", owed_results.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

/* delta_list_timer_queue.f */
+incdir+rtl
rtl/dltq_pkg.sv
rtl/dltq_ram.sv
rtl/dltq_alu.sv
rtl/dltq_seq.sv
rtl/delta_list_timer_queue.sv
tb/sv/tb_delta_list_timer_queue.sv
